FILE: design/ntc_pkg.sv
// Shared constants and types for the thermistor reader.
`timescale 1ns / 1ps

package ntc_pkg;

	localparam int FRAC_W   = 16;
	localparam int SQ_STEPS = 16;

	localparam logic [2:0] CFG_ENABLE = 3'd0;
	localparam logic [2:0] CFG_KIND   = 3'd1;
	localparam logic [2:0] CFG_LIMIT  = 3'd2;
	localparam logic [2:0] CFG_BETA   = 3'd3;
	localparam logic [2:0] CFG_R25    = 3'd4;
	localparam logic [2:0] CFG_PULLUP = 3'd5;

	typedef logic [1:0] status_t;
	localparam status_t STAT_OK  = 2'd0;
	localparam status_t STAT_OOR = 2'd1;
	localparam status_t STAT_ERR = 2'd2;
	localparam status_t STAT_NC  = 2'd3;

	localparam logic signed [12:0] FALLBACK_T16  = 13'sd400;
	localparam logic signed [12:0] VALID_MAX_T16 = 13'sd2080;
	localparam logic signed [12:0] T16_OFFSET    = 13'sd800;

	localparam int DEN_W = 48;
	localparam int NHI_W = 40;
	localparam int NUM_W = NHI_W + FRAC_W;
	localparam int Q_W   = 20;

	localparam logic [19:0] R_MAX_OHMS = 20'd1000000;
	localparam logic [25:0] N_SCALE    = 26'd47704000;
	localparam logic [22:0] BETA_SCALE = 23'd6553600;
	localparam logic [14:0] T0_X100    = 15'd29815;
	localparam logic signed [17:0] LN2_Q16 = 18'sd45426;

	localparam logic signed [21:0] KELVIN_1600 = 22'sd437040;
	localparam logic signed [21:0] LOW_1600    = -22'sd80000;
	localparam logic signed [21:0] HIGH_1600   = 22'sd240000;
	localparam logic signed [21:0] BIAS_1600   = 22'sd80050;
	localparam logic [19:0] RECIP_100 = 20'd671089;

endpackage

FILE: design/ntc_thermistor_reader.sv
// Top level of the NTC thermistor reader.
`timescale 1ns / 1ps

// Converts a divider sample to temperature via the beta equation, in sixteenths
// of a degree C, and tracks a saturating fault count and status. Clear requests,
// disabled and digital-kind samples go from acceptance straight to S_FIN, which
// raises the result. An analogue sample passes S_CHK, three passes through the
// shared log2 unit (each a start, normalising shifts, 16 squaring steps and done),
// S_LN, S_DEN, S_DCHK, a bit-serial divider giving a 20-bit quotient and S_SCALE.
// Samples caught by the rail and resistance checks go from S_CHK to S_FIN.
// One transaction is in flight at a time and the input is free again in the
// same cycle that the result is raised; a result waiting on out_stall holds the
// next one back. cfg_ready is always high.

module ntc_thermistor_reader import ntc_pkg::*; #(
	parameter int ADC_BITS = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [19:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                action,
	input  logic [ADC_BITS-1:0] raw_sample,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [12:0]  temperature,
	output logic [1:0]          status,
	output logic [7:0]          fault_cnt,
	output logic [ADC_BITS-1:0] raw_echo
);

	localparam int TOP_W  = 20 + ADC_BITS;
	localparam int RAIL_W = ADC_BITS + 6;
	localparam int LNW_   = (TOP_W > 32) ? TOP_W : 32;
	localparam int LOG_W  = $clog2(LNW_) + FRAC_W;
	localparam int DIFF_W = LOG_W + 2;
	localparam int LNP_W  = DIFF_W + 18;
	localparam logic [ADC_BITS-1:0] FS = '1;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_CHK   = 9'b000000010,
		S_LOG   = 9'b000000100,
		S_LN    = 9'b000001000,
		S_DEN   = 9'b000010000,
		S_DCHK  = 9'b000100000,
		S_DIV   = 9'b001000000,
		S_SCALE = 9'b010000000,
		S_FIN   = 9'b100000000
	} state_t;

	state_t state_q;

	logic enable_q, kind_q;
	logic [7:0] limit_q;
	logic [13:0] beta_q;
	logic [19:0] r25_q, pullup_q;

	logic [7:0] fault_q;
	status_t stat_q;
	logic signed [12:0] last_t_q;
	logic [ADC_BITS-1:0] last_raw_q;
	logic out_valid_q;

	logic action_q;
	logic [ADC_BITS-1:0] raw_q;
	logic fb_q;
	logic [TOP_W-1:0] top_q;
	logic [ADC_BITS-1:0] bot_q;
	logic [1:0] idx_q;
	logic log_start_q;
	logic [LOG_W-1:0] lt_q, lb_q, lr_q;
	logic signed [LNP_W-1:0] lnp_q;
	logic signed [DEN_W-1:0] d_q;
	logic [NUM_W-1:0] n_q;
	logic [DEN_W-1:0] rem_q;
	logic [Q_W-1:0] nlo_q, q_q;
	logic [$clog2(Q_W)-1:0] cnt_q;
	logic [38:0] prod_q;

	// sample checks
	logic [RAIL_W-1:0] raw50;
	logic rail;
	logic [TOP_W-1:0] top_c, rmax_c;
	logic [ADC_BITS-1:0] bot_c;
	logic fb_chk;

	assign raw50 = RAIL_W'(raw_q) * RAIL_W'(50);
	assign rail = (raw50 <= RAIL_W'(FS)) || (raw50 >= RAIL_W'(49 * ((1 << ADC_BITS) - 1)));
	assign top_c = TOP_W'(pullup_q) * TOP_W'(raw_q);
	assign bot_c = FS - raw_q;
	assign rmax_c = TOP_W'(R_MAX_OHMS) * TOP_W'(bot_c);
	assign fb_chk = rail || (top_c == '0) || (r25_q == '0) || (beta_q == '0) ||
		(top_c > rmax_c);

	// log2 unit
	logic [TOP_W-1:0] log_x;
	logic log_done;
	logic [LOG_W-1:0] log_res;

	always_comb begin
		unique case (idx_q)
			2'd0: log_x = top_q;
			2'd1: log_x = TOP_W'(bot_q);
			default: log_x = TOP_W'(r25_q);
		endcase
	end

	ntc_log2 #(.XW(TOP_W)) u_log2 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (log_start_q),
		.x      (log_x),
		.done   (log_done),
		.res    (log_res)
	);

	// natural log and denominator
	logic signed [DIFF_W-1:0] diff;
	logic signed [LNP_W-17:0] ln16;
	logic signed [DEN_W-1:0] d_c;
	assign diff = $signed(DIFF_W'(lt_q)) - $signed(DIFF_W'(lb_q)) - $signed(DIFF_W'(lr_q));
	assign ln16 = lnp_q[LNP_W-1:16];
	assign d_c = $signed(DEN_W'(beta_q) * DEN_W'(BETA_SCALE)) +
		DEN_W'(ln16) * $signed(DEN_W'(T0_X100));

	// serial divider step
	logic [DEN_W-1:0] trial;
	logic ge;
	assign trial = {rem_q[DEN_W-2:0], nlo_q[Q_W-1]};
	assign ge = trial >= DEN_W'(d_q);

	// scaling to sixteenths
	logic signed [21:0] c1600, vb;
	logic in_rng;
	logic signed [12:0] t16;
	logic valid_rd;
	logic [7:0] fault_inc;
	assign c1600 = $signed(22'(q_q)) - KELVIN_1600;
	assign in_rng = (c1600 >= LOW_1600) && (c1600 <= HIGH_1600);
	assign vb = c1600 + BIAS_1600;
	assign t16 = fb_q ? FALLBACK_T16 : ($signed(prod_q[38:26]) - T16_OFFSET);
	assign valid_rd = (t16 != FALLBACK_T16) && (t16 <= VALID_MAX_T16);
	assign fault_inc = (fault_q == 8'hFF) ? fault_q : fault_q + 8'd1;

	logic fin_go;
	assign fin_go = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			enable_q <= 1'b0;
			kind_q <= 1'b0;
			limit_q <= 8'd3;
			beta_q <= 14'd3950;
			r25_q <= 20'd10000;
			pullup_q <= 20'd10000;
			fault_q <= '0;
			stat_q <= STAT_OK;
			last_t_q <= '0;
			last_raw_q <= '0;
			out_valid_q <= 1'b0;
			log_start_q <= 1'b0;
			idx_q <= '0;
		end else begin
			log_start_q <= 1'b0;
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_ENABLE: enable_q <= cfg_data[0];
					CFG_KIND:   kind_q <= cfg_data[0];
					CFG_LIMIT:  limit_q <= cfg_data[7:0];
					CFG_BETA:   beta_q <= cfg_data[13:0];
					CFG_R25:    r25_q <= cfg_data;
					CFG_PULLUP: pullup_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= (action || !enable_q || kind_q) ? S_FIN : S_CHK;
					end
				end
				S_CHK: begin
					if (fb_chk) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_LOG;
						idx_q <= 2'd0;
						log_start_q <= 1'b1;
					end
				end
				S_LOG: begin
					if (log_done) begin
						if (idx_q == 2'd2) begin
							state_q <= S_LN;
						end else begin
							idx_q <= idx_q + 2'd1;
							log_start_q <= 1'b1;
						end
					end
				end
				S_LN:  state_q <= S_DEN;
				S_DEN: state_q <= S_DCHK;
				S_DCHK: begin
					if (d_q <= 0 || ({12'b0, n_q} >= {d_q[DEN_W-1:0], 20'b0})) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (cnt_q == $clog2(Q_W)'(Q_W - 1)) begin
						state_q <= S_SCALE;
					end
				end
				S_SCALE: state_q <= S_FIN;
				S_FIN: begin
					if (fin_go) begin
						state_q <= S_IDLE;
						out_valid_q <= 1'b1;
						priority if (action_q) begin
							fault_q <= '0;
							if (stat_q == STAT_ERR) begin
								stat_q <= STAT_OK;
							end
						end else if (!enable_q) begin
							stat_q <= STAT_NC;
						end else if (kind_q) begin
							stat_q <= STAT_ERR;
						end else begin
							last_raw_q <= raw_q;
							last_t_q <= t16;
							if (valid_rd) begin
								stat_q <= STAT_OK;
								fault_q <= '0;
							end else begin
								fault_q <= fault_inc;
								stat_q <= (fault_inc >= limit_q) ? STAT_ERR : STAT_OOR;
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				action_q <= action;
				raw_q <= raw_sample;
				fb_q <= 1'b0;
			end
			S_CHK: begin
				top_q <= top_c;
				bot_q <= bot_c;
				fb_q <= fb_chk;
			end
			S_LOG: begin
				if (log_done) begin
					unique case (idx_q)
						2'd0: lt_q <= log_res;
						2'd1: lb_q <= log_res;
						default: lr_q <= log_res;
					endcase
				end
			end
			S_LN: lnp_q <= LNP_W'(diff) * LNP_W'(LN2_Q16);
			S_DEN: begin
				d_q <= d_c;
				n_q <= {NHI_W'(N_SCALE) * NHI_W'(beta_q), FRAC_W'(0)};
			end
			S_DCHK: begin
				rem_q <= DEN_W'(n_q[NUM_W-1:Q_W]);
				nlo_q <= n_q[Q_W-1:0];
				cnt_q <= '0;
				if (d_q <= 0 || ({12'b0, n_q} >= {d_q[DEN_W-1:0], 20'b0})) begin
					fb_q <= 1'b1;
				end
			end
			S_DIV: begin
				rem_q <= ge ? trial - DEN_W'(d_q) : trial;
				q_q <= {q_q[Q_W-2:0], ge};
				nlo_q <= nlo_q << 1;
				cnt_q <= cnt_q + 1'b1;
			end
			S_SCALE: begin
				prod_q <= 39'(vb[18:0]) * 39'(RECIP_100);
				if (!in_rng) begin
					fb_q <= 1'b1;
				end
			end
			S_FIN: ;
			default: ;
		endcase
	end

	assign cfg_ready = 1'b1;
	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign temperature = last_t_q;
	assign status = stat_q;
	assign fault_cnt = fault_q;
	assign raw_echo = last_raw_q;

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FIN))
		else $error("result raised outside completion");

	a_ok_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		(stat_q == STAT_OK) |-> (fault_q == 8'd0))
		else $error("status ok with nonzero fault count");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < DEN_W'(d_q)))
		else $error("divider remainder not below divisor");

	a_busy_no_cfg_change: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |=> $stable(n_q))
		else $error("numerator changed during division");

endmodule

FILE: design/ntc_log2.sv
// Iterative base-2 logarithm: normalising shifter then repeated squaring.
`timescale 1ns / 1ps

module ntc_log2 import ntc_pkg::*; #(
	parameter int XW = 30,
	localparam int NW = (XW > 32) ? XW : 32,
	localparam int EW = $clog2(NW),
	localparam int RW = EW + FRAC_W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [XW-1:0] x,
	output logic          done,
	output logic [RW-1:0] res
);

	typedef enum logic [2:0] {
		L_IDLE = 3'b001,
		L_NORM = 3'b010,
		L_SQR  = 3'b100
	} lstate_t;

	lstate_t state_q;
	logic [NW-1:0] nrm_q;
	logic [EW-1:0] e_q;
	logic [31:0] m_q;
	logic [FRAC_W-1:0] f_q;
	logic [$clog2(SQ_STEPS)-1:0] cnt_q;
	logic done_q;
	logic [RW-1:0] res_q;
	logic [63:0] sq;
	logic [FRAC_W-1:0] f_nxt;

	assign sq = {32'b0, m_q} * {32'b0, m_q};
	assign f_nxt = {f_q[FRAC_W-2:0], sq[63]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				L_IDLE: begin
					if (start) begin
						state_q <= L_NORM;
					end
				end
				L_NORM: begin
					if (nrm_q[NW-1]) begin
						state_q <= L_SQR;
					end
				end
				L_SQR: begin
					if (cnt_q == $clog2(SQ_STEPS)'(SQ_STEPS - 1)) begin
						state_q <= L_IDLE;
						done_q <= 1'b1;
					end
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			L_IDLE: begin
				nrm_q <= NW'(x);
				e_q <= EW'(NW - 1);
				cnt_q <= '0;
				f_q <= '0;
			end
			L_NORM: begin
				priority if (nrm_q[NW-1 -: 8] == 8'd0) begin
					nrm_q <= nrm_q << 8;
					e_q <= e_q - EW'(8);
				end else if (!nrm_q[NW-1]) begin
					nrm_q <= nrm_q << 1;
					e_q <= e_q - EW'(1);
				end else begin
					m_q <= nrm_q[NW-1 -: 32];
				end
			end
			L_SQR: begin
				m_q <= sq[63] ? sq[63:32] : sq[62:31];
				f_q <= f_nxt;
				cnt_q <= cnt_q + 1'b1;
				res_q <= {e_q, f_nxt};
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign res = res_q;

endmodule

FILE: tb/tb_ntc_thermistor_reader.sv
// Self-checking testbench for the NTC thermistor reader, with a built-in predictor.
`timescale 1ns / 1ps

module tb_ntc_thermistor_reader;
	import ntc_pkg::*;

	localparam int FS = 1023;

	typedef struct {
		logic       act;
		logic [9:0] raw;
	} sample_req_t;

	typedef struct {
		logic signed [12:0] temp;
		status_t            stat;
		logic [7:0]         cnt;
		logic [9:0]         raw;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [19:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic action = 1'b0;
	logic [9:0] raw_sample = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [12:0] temperature;
	logic [1:0] status;
	logic [7:0] fault_cnt;
	logic [9:0] raw_echo;

	ntc_thermistor_reader #(.ADC_BITS(10)) uut (.*);

	always #4 clk = ~clk;

	// predictor copy of registers and state
	logic        m_enable = 1'b0, m_kind = 1'b0;
	logic [7:0]  m_limit = 8'd3;
	logic [13:0] m_beta = 14'd3950;
	logic [19:0] m_r25 = 20'd10000, m_pullup = 20'd10000;
	logic [7:0]  m_faults = '0;
	status_t     m_stat = STAT_OK;
	logic signed [12:0] m_temp = '0;
	logic [9:0]  m_raw = '0;

	sample_req_t pending_q[$];
	reading_t    readings_q[$];
	int errors = 0, n_in = 0, n_out = 0, n_cfg = 0, n_sent = 0;
	bit quiet = 1'b0;
	int gap_left = 0, stall_left = 0, hold_left = 0;
	bit hold_done = 1'b0;

	function automatic longint log2_fix(longint unsigned x);
		int e;
		longint unsigned m;
		longint f;
		e = 63;
		f = 0;
		while (e > 0 && x[e] == 1'b0)
			e--;
		m = (e >= 31) ? (x >> (e - 31)) : (x << (31 - e));
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 31;
			f = f * 2;
			if (m >= 64'h1_0000_0000) begin
				m = m >> 1;
				f = f | 1;
			end
		end
		return longint'(e) * 65536 + f;
	endfunction

	function automatic longint fdiv(longint p, longint d);
		longint q;
		q = p / d;
		if ((p % d) != 0 && p < 0)
			q--;
		return q;
	endfunction

	function automatic logic signed [12:0] raw_to_t16(logic [9:0] raw);
		longint unsigned top, bot, n, tk;
		longint diff, ln16, d, c1600;
		if (raw * 50 <= FS || raw * 50 >= 49 * FS)
			return FALLBACK_T16;
		top = longint'(m_pullup) * raw;
		bot = FS - raw;
		if (top == 0 || m_r25 == 0 || m_beta == 0)
			return FALLBACK_T16;
		if (top > 64'd1000000 * bot)
			return FALLBACK_T16;
		diff = log2_fix(top) - log2_fix(bot) - log2_fix(m_r25);
		ln16 = (diff * 45426) >>> 16;
		d = longint'(100) * m_beta * 65536 + longint'(29815) * ln16;
		if (d <= 0)
			return FALLBACK_T16;
		n = longint'(29815) * m_beta * 65536;
		tk = (64'd1600 * n) / longint'(d);
		c1600 = longint'(tk) - 437040;
		if (c1600 < -80000 || c1600 > 240000)
			return FALLBACK_T16;
		return 13'(fdiv(c1600 + 50, 100));
	endfunction

	task automatic predict_reading(sample_req_t it);
		logic signed [12:0] t;
		reading_t r;
		if (it.act) begin
			m_faults = '0;
			if (m_stat == STAT_ERR)
				m_stat = STAT_OK;
		end else if (!m_enable) begin
			m_stat = STAT_NC;
		end else if (m_kind) begin
			m_stat = STAT_ERR;
		end else begin
			t = raw_to_t16(it.raw);
			m_raw = it.raw;
			m_temp = t;
			if (t != FALLBACK_T16 && t <= VALID_MAX_T16) begin
				m_stat = STAT_OK;
				m_faults = '0;
			end else begin
				m_stat = STAT_OOR;
				if (m_faults != 8'd255)
					m_faults++;
				if (m_faults >= m_limit)
					m_stat = STAT_ERR;
			end
		end
		r.temp = m_temp;
		r.stat = m_stat;
		r.cnt = m_faults;
		r.raw = m_raw;
		readings_q.push_back(r);
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		$display("MISMATCH result %0d %s: got %0d expected %0d", n_out, what, got, want);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// driver
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			predict_reading('{act: action, raw: raw_sample});
			n_in++;
		end
		if (in_valid && in_stall) begin
			// payload held while stalled
		end else if (gap_left > 0) begin
			gap_left <= gap_left - 1;
			in_valid <= 1'b0;
		end else if (pending_q.size() > 0) begin
			sample_req_t it;
			it = pending_q.pop_front();
			action <= it.act;
			raw_sample <= it.raw;
			in_valid <= 1'b1;
			gap_left <= pick_gap();
		end else begin
			in_valid <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			reading_t e;
			if (readings_q.size() == 0) begin
				report_mismatch("unexpected transaction", 1, 0);
			end else begin
				e = readings_q.pop_front();
				if (temperature !== e.temp)
					report_mismatch("temperature", temperature, e.temp);
				if (status !== e.stat)
					report_mismatch("status", status, e.stat);
				if (fault_cnt !== e.cnt)
					report_mismatch("fault_cnt", fault_cnt, e.cnt);
				if (raw_echo !== e.raw)
					report_mismatch("raw_echo", raw_echo, e.raw);
			end
			n_out++;
		end
		// one long hold-off mid-run while the driver keeps offering
		if (!hold_done && n_out == 600) begin
			hold_done <= 1'b1;
			hold_left <= 500;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else begin
			stall_left <= pick_gap();
			out_stall <= 1'b0;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [19:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		n_cfg++;
		case (idx)
			CFG_ENABLE: m_enable = val[0];
			CFG_KIND:   m_kind = val[0];
			CFG_LIMIT:  m_limit = val[7:0];
			CFG_BETA:   m_beta = val[13:0];
			CFG_R25:    m_r25 = val;
			CFG_PULLUP: m_pullup = val;
			default: ;
		endcase
	endtask

	// wait until every queued transaction has come back
	task automatic drain();
		while (n_out < n_sent)
			@(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic push_item(logic act, logic [9:0] raw);
		pending_q.push_back('{act: act, raw: raw});
		n_sent++;
	endtask

	// random traffic: mostly samples, some clears, some near the rails
	task automatic push_random(int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 8)
				push_item(1'b1, 10'($urandom));
			else if (r < 18)
				push_item(1'b0, $urandom_range(0, 1) ? 10'($urandom_range(0, 21))
					: 10'($urandom_range(1002, 1023)));
			else
				push_item(1'b0, 10'($urandom));
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// disabled after reset: not connected, clear still acts
		push_item(1'b0, 10'd512);
		push_item(1'b1, 10'd0);
		push_item(1'b0, 10'd1023);
		drain();
		write_reg(CFG_ENABLE, 20'd1);
		push_item(1'b0, 10'd0);
		push_item(1'b0, 10'd20);
		push_item(1'b0, 10'd21);
		push_item(1'b0, 10'd1002);
		push_item(1'b0, 10'd1003);
		push_item(1'b0, 10'd1023);
		push_item(1'b1, 10'h3FF);
		push_item(1'b0, 10'd512);
		push_item(1'b0, 10'd100);
		push_item(1'b0, 10'd30);
		push_item(1'b0, 10'd1000);
		push_item(1'b0, 10'd990);
		drain();
		write_reg(CFG_KIND, 20'd1);
		push_item(1'b0, 10'd512);
		push_item(1'b1, 10'd0);
		drain();
		write_reg(CFG_KIND, 20'hFFFFE);
		write_reg(3'd6, 20'hFFFFF);
		write_reg(3'd7, 20'd0);
		push_random(150);
		drain();

		quiet = 1'b1;
		write_reg(CFG_LIMIT, 20'd0);
		push_random(150);
		drain();
		quiet = 1'b0;

		// long run of rail samples to saturate the fault count
		write_reg(CFG_LIMIT, 20'hFFF);
		for (int i = 0; i < 270; i++)
			push_item(1'b0, 10'($urandom_range(0, 20)));
		push_random(30);
		drain();

		write_reg(CFG_BETA, 20'd1000);
		write_reg(CFG_LIMIT, 20'd3);
		push_random(150);
		drain();
		write_reg(CFG_BETA, 20'd10000);
		write_reg(CFG_R25, 20'd100);
		push_random(150);
		drain();
		write_reg(CFG_BETA, 20'hFFFFF);
		write_reg(CFG_R25, 20'd1000000);
		push_random(150);
		drain();
		write_reg(CFG_BETA, 20'd3950);
		write_reg(CFG_R25, 20'd10000);
		write_reg(CFG_PULLUP, 20'd100);
		push_random(150);
		drain();
		write_reg(CFG_PULLUP, 20'd1000000);
		push_random(150);
		drain();
		write_reg(CFG_PULLUP, 20'hFFFFF);
		write_reg(CFG_R25, 20'hFFFFF);
		push_random(100);
		drain();
		// zero registers fall back
		write_reg(CFG_PULLUP, 20'd0);
		push_random(20);
		drain();
		write_reg(CFG_PULLUP, 20'd10000);
		write_reg(CFG_R25, 20'd0);
		push_random(20);
		drain();
		write_reg(CFG_R25, 20'd10000);
		write_reg(CFG_BETA, 20'd0);
		push_random(20);
		drain();
		write_reg(CFG_BETA, 20'($urandom_range(1000, 10000)));
		write_reg(CFG_R25, 20'($urandom_range(100, 1000000)));
		write_reg(CFG_PULLUP, 20'($urandom_range(100, 1000000)));
		write_reg(CFG_LIMIT, 20'($urandom_range(1, 10)));
		push_random(400);
		drain();
		write_reg(CFG_ENABLE, 20'd0);
		push_random(30);
		drain();

		$display("covered %0d input transactions, %0d results, %0d register writes",
			n_in, n_out, n_cfg);
		if (errors == 0 && readings_q.size() == 0)
			$display("ntc_thermistor_reader regression: pass");
		else
			$display("ntc_thermistor_reader regression: fail");
		$finish;
	end

	initial begin
		#20ms;
		$display("timeout with %0d results outstanding", readings_q.size());
		$display("ntc_thermistor_reader regression: fail");
		$finish;
	end

endmodule

FILE: files.f
design/ntc_pkg.sv
design/ntc_log2.sv
design/ntc_thermistor_reader.sv
tb/tb_ntc_thermistor_reader.sv
